// ===== rtl/core/block_extent_coalescer_macros.svh =====
// Assertion macros used by the extent coalescer checker.
`ifndef BLOCK_EXTENT_COALESCER_MACROS_SVH
`define BLOCK_EXTENT_COALESCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BEC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("extent coalescer check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BEC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("extent coalescer check failed");

`endif

// ===== rtl/core/bec_pkg.sv =====
// Shared types and constants of the block extent coalescer.
package bec_pkg;

    localparam int BLOCK_W     = 32;
    localparam int SECTOR_W    = 40;
    localparam int COUNT_W     = 32;
    localparam int BSB_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int SECTOR_BITS = 9;
    localparam int MAX_BSB     = 16;
    localparam int MAX_SHIFT   = MAX_BSB - SECTOR_BITS;
    localparam int SH_W        = 3;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [BSB_W-1:0] BSB_RESET = BSB_W'(12);

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_BITS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_START    = 1'b1;

    // One closed run (or the error marker) in block units.
    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] first_block;
        logic [COUNT_W-1:0] block_count;
        logic               err;
        logic               fin;
    } bec_raw_t;

    // One result beat in sector units.
    typedef struct packed {
        logic [SECTOR_W-1:0] start_sector;
        logic [COUNT_W-1:0]  sector_count;
        logic                err;
        logic                fin;
    } bec_result_t;

endpackage

// ===== rtl/core/bec_run_tracker.sv =====
// Run tracking, extent limit and result slot registers.
module bec_run_tracker
    import bec_pkg::*;
#(
    parameter int MAX_EXTENTS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [BLOCK_W-1:0] block_number,
    input  logic               list_end,
    output bec_raw_t           slot0,
    output bec_raw_t           slot1
);

    localparam int EMIT_W = $clog2(MAX_EXTENTS + 1);
    localparam logic [EMIT_W-1:0] MAX_LIM = EMIT_W'(MAX_EXTENTS);

    logic [BLOCK_W-1:0] prev_block_reg;
    logic [BLOCK_W-1:0] run_first_reg;
    logic [COUNT_W-1:0] run_count_reg;
    logic [EMIT_W-1:0]  emitted_reg;
    logic               run_open_reg;
    logic               limit_hit_reg;
    bec_raw_t           slot0_reg;
    bec_raw_t           slot1_reg;

    bec_raw_t           slot0_next;
    bec_raw_t           slot1_next;
    logic               cont;
    logic               brk;
    logic               emit0;
    logic               lim0;
    logic               emit1;
    logic               lim1;
    logic               limit_all;
    logic [EMIT_W-1:0]  emitted_mid;
    logic [BLOCK_W-1:0] new_first;
    logic [COUNT_W-1:0] new_count;

    always_comb
    begin
        cont        = run_open_reg && (prev_block_reg != '1) &&
                      (block_number == BLOCK_W'(prev_block_reg + 1'b1));
        brk         = run_open_reg && !cont;
        emit0       = brk && (emitted_reg < MAX_LIM);
        lim0        = brk && !(emitted_reg < MAX_LIM);
        emitted_mid = emitted_reg + EMIT_W'(emit0);
        emit1       = list_end && (emitted_mid < MAX_LIM);
        lim1        = list_end && !(emitted_mid < MAX_LIM);
        limit_all   = limit_hit_reg || lim0 || lim1;

        if (cont)
        begin
            new_first = run_first_reg;
            new_count = (run_count_reg == '1) ? run_count_reg
                                              : COUNT_W'(run_count_reg + 1'b1);
        end
        else
        begin
            new_first = block_number;
            new_count = COUNT_W'(1);
        end

        slot0_next.valid       = accept && emit0;
        slot0_next.first_block = run_first_reg;
        slot0_next.block_count = run_count_reg;
        slot0_next.err         = 1'b0;
        slot0_next.fin         = 1'b0;

        // error marker takes the final slot when the limit was crossed
        slot1_next.valid       = accept && list_end && (limit_all || emit1);
        slot1_next.first_block = new_first;
        slot1_next.block_count = new_count;
        slot1_next.err         = limit_all;
        slot1_next.fin         = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_block_reg <= '0;
            run_first_reg  <= '0;
            run_count_reg  <= '0;
            emitted_reg    <= '0;
            run_open_reg   <= 1'b0;
            limit_hit_reg  <= 1'b0;
            slot0_reg      <= '0;
            slot1_reg      <= '0;
        end
        else
        begin
            slot0_reg <= slot0_next;
            slot1_reg <= slot1_next;
            if (accept)
            begin
                if (list_end)
                begin
                    prev_block_reg <= '0;
                    run_first_reg  <= '0;
                    run_count_reg  <= '0;
                    emitted_reg    <= '0;
                    run_open_reg   <= 1'b0;
                    limit_hit_reg  <= 1'b0;
                end
                else
                begin
                    prev_block_reg <= block_number;
                    run_first_reg  <= new_first;
                    run_count_reg  <= new_count;
                    emitted_reg    <= emitted_mid;
                    run_open_reg   <= 1'b1;
                    limit_hit_reg  <= limit_hit_reg || lim0;
                end
            end
        end
    end

    assign slot0 = slot0_reg;
    assign slot1 = slot1_reg;

endmodule

// ===== rtl/core/bec_extent_calc.sv =====
// Block-to-sector conversion of one result slot.
module bec_extent_calc
    import bec_pkg::*;
(
    input  bec_raw_t              raw,
    input  logic [SH_W-1:0]       shift,
    input  logic [CFG_DATA_W-1:0] partition_start,
    output bec_result_t           res
);

    localparam int WIDE_W = COUNT_W + MAX_SHIFT;

    logic [SECTOR_W-1:0] start_sum;
    logic [WIDE_W-1:0]   count_wide;

    always_comb
    begin
        start_sum  = SECTOR_W'(partition_start) + (SECTOR_W'(raw.first_block) << shift);
        count_wide = WIDE_W'(raw.block_count) << shift;

        if (raw.err)
        begin
            res.start_sector = '0;
            res.sector_count = '0;
        end
        else
        begin
            res.start_sector = start_sum;
            res.sector_count = (|count_wide[WIDE_W-1:COUNT_W]) ? '1
                                                                : count_wide[COUNT_W-1:0];
        end
        res.err = raw.err;
        res.fin = raw.fin;
    end

endmodule

// ===== rtl/core/bec_result_fifo.sv =====
// Result queue with two write ports and one read port.
module bec_result_fifo
    import bec_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr0_valid,
    input  bec_result_t       wr0_data,
    input  logic              wr1_valid,
    input  bec_result_t       wr1_data,
    input  logic              rd_pop,
    output logic              rd_valid,
    output bec_result_t       rd_data,
    output logic [CNT_W-1:0]  fill
);

    bec_result_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr1_addr;
    logic [CNT_W-1:0] n_wr;

    always_comb
    begin
        wr1_addr = wr0_valid ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        n_wr     = CNT_W'(wr0_valid) + CNT_W'(wr1_valid);
    end

    always_ff @(posedge clk)
    begin
        if (wr0_valid)
        begin
            mem[wr_ptr_reg] <= wr0_data;
        end
        if (wr1_valid)
        begin
            mem[wr1_addr] <= wr1_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= PTR_W'(wr_ptr_reg + n_wr);
            if (rd_pop)
            begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= CNT_W'(count_reg + n_wr - CNT_W'(rd_pop));
        end
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign fill     = count_reg;

endmodule

// ===== rtl/core/block_extent_coalescer.sv =====
// Path: an input beat's results are registered in the slot registers, then written into the result queue.
// Throughput: one block number per cycle while in_stall is low and items yield at most one result;
// an item that yields two results costs two output beats on the single result port.
// Intake stalls when the 4-entry result queue plus the slot registers cannot take two more.
// Reset (rst_n, async, active low): run state and queue cleared, block_size_bits = 12,
// partition_start_sector = 0.
module block_extent_coalescer
    import bec_pkg::*;
#(
    parameter int MAX_EXTENTS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BLOCK_W-1:0]    block_number,
    input  logic                  list_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SECTOR_W-1:0]   extent_start_sector,
    output logic [COUNT_W-1:0]    extent_sector_count,
    output logic                  too_many_extents,
    output logic                  final_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [BSB_W-1:0]      bsb_reg;
    logic [CFG_DATA_W-1:0] part_start_reg;
    logic [SH_W-1:0]       shift;
    logic                  accept;
    logic                  pop;
    logic [CNT_W-1:0]      fill;
    logic [CNT_W:0]        pending;
    bec_raw_t              slot0;
    bec_raw_t              slot1;
    bec_result_t           res0;
    bec_result_t           res1;
    bec_result_t           head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsb_reg        <= BSB_RESET;
            part_start_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE_BITS: bsb_reg        <= cfg_data[BSB_W-1:0];
                CFG_PARTITION_START: part_start_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (bsb_reg < BSB_W'(SECTOR_BITS))
        begin
            shift = '0;
        end
        else if (bsb_reg > BSB_W'(MAX_BSB))
        begin
            shift = SH_W'(MAX_SHIFT);
        end
        else
        begin
            shift = SH_W'(bsb_reg - BSB_W'(SECTOR_BITS));
        end
    end

    // slot register always drains into the queue next cycle
    assign pending  = (CNT_W + 1)'(fill) + (CNT_W + 1)'(slot0.valid)
                    + (CNT_W + 1)'(slot1.valid);
    assign in_stall = pending > (CNT_W + 1)'(FIFO_DEPTH - 2);
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    bec_run_tracker #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .block_number (block_number),
        .list_end     (list_end),
        .slot0        (slot0),
        .slot1        (slot1)
    );

    bec_extent_calc u_calc0 (
        .raw             (slot0),
        .shift           (shift),
        .partition_start (part_start_reg),
        .res             (res0)
    );

    bec_extent_calc u_calc1 (
        .raw             (slot1),
        .shift           (shift),
        .partition_start (part_start_reg),
        .res             (res1)
    );

    bec_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr0_valid (slot0.valid),
        .wr0_data  (res0),
        .wr1_valid (slot1.valid),
        .wr1_data  (res1),
        .rd_pop    (pop),
        .rd_valid  (out_valid),
        .rd_data   (head),
        .fill      (fill)
    );

    assign extent_start_sector = head.start_sector;
    assign extent_sector_count = head.sector_count;
    assign too_many_extents    = head.err;
    assign final_result        = head.fin;

endmodule

// ===== rtl/core/bec_checker.sv =====
// Port-level checker for the block extent coalescer, bound to the top level.
`include "block_extent_coalescer_macros.svh"

module bec_checker
    import bec_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [SECTOR_W-1:0]   extent_start_sector,
    input logic [COUNT_W-1:0]    extent_sector_count,
    input logic                  too_many_extents,
    input logic                  final_result
);

    // error beat closes the list
    `BEC_ASSERT_IMP(a_err_is_final, out_valid && too_many_extents, final_result)

    // error beat carries no extent
    `BEC_ASSERT_IMP(a_err_zero, out_valid && too_many_extents, (extent_start_sector == '0) && (extent_sector_count == '0))

    // a real extent always covers at least one sector
    `BEC_ASSERT_IMP(a_extent_nonempty, out_valid && !too_many_extents, extent_sector_count != '0)

    // held result beat keeps its payload
    `BEC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(extent_start_sector) && $stable(extent_sector_count) && $stable(final_result))

endmodule

bind block_extent_coalescer bec_checker u_bec_checker (.*);

// ===== tb/block_extent_coalescer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for block_extent_coalescer: extent predictor, random traffic and stalls.
module block_extent_coalescer_tb;
    import bec_pkg::*;

    localparam int MAX_EXT       = 64;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TARGET_BLOCKS = 1900;
    localparam int PRINT_LIMIT   = 50;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [BLOCK_W-1:0]    block_number = '0;
    logic                  list_end = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SECTOR_W-1:0]   extent_start_sector;
    logic [COUNT_W-1:0]    extent_sector_count;
    logic                  too_many_extents;
    logic                  final_result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLOCK_SIZE_BITS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    block_extent_coalescer #(.MAX_EXTENTS(MAX_EXT)) dut (.*);

    // predictor state
    logic [BSB_W-1:0]      bsb_reg;
    logic [CFG_DATA_W-1:0] part_reg;
    logic [BLOCK_W-1:0]    prev_blk;
    logic [BLOCK_W-1:0]    run_first;
    logic [31:0]           run_len;
    logic [15:0]           emitted;
    logic                  run_open;
    logic                  over_limit;
    bec_result_t           expected_extents[$];
    bec_result_t           step_results[$];

    int n_blocks_in = 0;
    int n_extents_out = 0;
    int n_lists = 0;
    int n_overflow_lists = 0;
    int n_reg_writes = 0;
    int n_errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit quiet = 1'b0;

    int stall_mode = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_level = 1'b0;
    bit stall_next;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_run();
        prev_blk   = '0;
        run_first  = '0;
        run_len    = '0;
        emitted    = '0;
        run_open   = 1'b0;
        over_limit = 1'b0;
    endfunction

    function automatic void close_extent(input logic fin);
        int unsigned bits;
        logic [63:0] cnt;
        bec_result_t r;
        if (emitted >= MAX_EXT)
        begin
            over_limit = 1'b1;
            return;
        end
        bits = bsb_reg;
        if (bits < SECTOR_BITS)
            bits = SECTOR_BITS;
        if (bits > MAX_BSB)
            bits = MAX_BSB;
        r.start_sector = SECTOR_W'(part_reg) + (SECTOR_W'(run_first) << (bits - SECTOR_BITS));
        cnt = 64'(run_len) << (bits - SECTOR_BITS);
        r.sector_count = (cnt > 64'hFFFF_FFFF) ? '1 : cnt[31:0];
        r.err = 1'b0;
        r.fin = fin;
        step_results.push_back(r);
        emitted++;
    endfunction

    function automatic void coalesce_block(input logic [BLOCK_W-1:0] blk, input logic last);
        bec_result_t err_beat;
        step_results.delete();
        if (run_open && prev_blk != '1 && blk == prev_blk + 1'b1)
        begin
            if (run_len != '1)
                run_len++;
        end
        else
        begin
            if (run_open)
                close_extent(1'b0);
            run_first = blk;
            run_len   = 32'd1;
            run_open  = 1'b1;
        end
        prev_blk = blk;
        if (last)
        begin
            close_extent(1'b1);
            if (over_limit)
            begin
                // error beat takes the place of the final extent
                if (step_results.size() == 2)
                    void'(step_results.pop_back());
                err_beat = '{start_sector: '0, sector_count: '0, err: 1'b1, fin: 1'b1};
                step_results.push_back(err_beat);
                n_overflow_lists++;
            end
            n_lists++;
            clear_run();
        end
        foreach (step_results[i])
            expected_extents.push_back(step_results[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
            $display("%0t ns mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic check_extent();
        bec_result_t want;
        n_extents_out++;
        if (expected_extents.size() == 0)
        begin
            report_mismatch("unexpected result beat", extent_start_sector, 0);
            return;
        end
        want = expected_extents.pop_front();
        if (extent_start_sector !== want.start_sector)
            report_mismatch("extent_start_sector", extent_start_sector, want.start_sector);
        if (extent_sector_count !== want.sector_count)
            report_mismatch("extent_sector_count", extent_sector_count, want.sector_count);
        if (too_many_extents !== want.err)
            report_mismatch("too_many_extents", too_many_extents, want.err);
        if (final_result !== want.fin)
            report_mismatch("final_result", final_result, want.fin);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                coalesce_block(block_number, list_end);
                n_blocks_in++;
            end
            if (out_valid && !out_stall)
                check_extent();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns watchdog: no beat for %0d cycles, %0d results outstanding",
                     $realtime, IDLE_LIMIT, expected_extents.size());
            $display("** block_extent_coalescer: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 3) == 0);
            2: stall_next = ($urandom_range(0, 3) != 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_left  = $urandom_range(1, 16);
                    hold_level = ~hold_level;
                end
                hold_left--;
                stall_next = hold_level;
            end
        endcase
        out_stall <= quiet ? 1'b0 : stall_next;
    end

    task automatic send_block(input logic [BLOCK_W-1:0] blk, input logic last);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid     <= 1'b1;
        block_number <= blk;
        list_end     <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic settle();
        stop_input();
        while (expected_extents.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BLOCK_SIZE_BITS)
            bsb_reg = data[BSB_W-1:0];
        else
            part_reg = data;
        n_reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // upper bits of the block size word are don't-care; keep them noisy
    task automatic apply_config(input logic [BSB_W-1:0] bsb, input logic [CFG_DATA_W-1:0] part);
        settle();
        write_reg(CFG_BLOCK_SIZE_BITS, ($urandom & ~32'h1F) | CFG_DATA_W'(bsb));
        write_reg(CFG_PARTITION_START, part);
    endtask

    function automatic logic [BLOCK_W-1:0] random_base();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return '1 - $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_file(input int n, input int brk_pct, input logic [BLOCK_W-1:0] base);
        logic [BLOCK_W-1:0] blk;
        blk = base;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                if ($urandom_range(0, 99) < brk_pct)
                begin
                    case ($urandom_range(0, 5))
                        0: blk = $urandom;
                        1: blk = blk + 32'd2;
                        2: blk = blk;
                        3: blk = blk - 1'b1;
                        4: blk = $urandom_range(0, 63);
                        default: blk = '1 - $urandom_range(0, 3);
                    endcase
                end
                else
                begin
                    blk = blk + 1'b1;
                end
            end
            send_block(blk, i == n - 1);
        end
    endtask

    task automatic random_config();
        logic [BSB_W-1:0] bsb;
        bsb = ($urandom_range(0, 4) == 0) ? BSB_W'($urandom) : BSB_W'($urandom_range(9, 16));
        apply_config(bsb, ($urandom_range(0, 3) == 0) ? '1 : CFG_DATA_W'($urandom));
    endtask

    task automatic test_directed();
        send_block('0, 1'b1);
        send_block('1, 1'b1);
        // wrap at the top block, break on the last beat
        send_block(32'hFFFF_FFFE, 1'b0);
        send_block(32'hFFFF_FFFF, 1'b0);
        send_block(32'h0000_0000, 1'b1);
        send_block(32'd5, 1'b0);
        send_block(32'd6, 1'b0);
        send_block(32'd7, 1'b0);
        send_block(32'd8, 1'b1);
        send_block(32'hAAAA_AAAA, 1'b0);
        send_block(32'h5555_5555, 1'b1);
        send_block(32'h7FFF_FFFF, 1'b0);
        send_block(32'h8000_0000, 1'b1);
        send_block(32'd100, 1'b0);
        send_block(32'd100, 1'b1);
    endtask

    task automatic test_block_size();
        logic [BSB_W-1:0] sizes[7] = '{9, 16, 0, 31, 8, 17, 13};
        foreach (sizes[i])
        begin
            apply_config(sizes[i], (i % 2 == 0) ? '0 : '1);
            send_block('1, 1'b1);
            send_file($urandom_range(1, 6), 40, random_base());
        end
        apply_config(BSB_W'(12), CFG_DATA_W'($urandom));
        send_file(4, 0, $urandom);
    endtask

    task automatic test_extent_limit();
        int sizes[5] = '{63, 64, 65, 66, 90};
        random_config();
        foreach (sizes[i])
            send_file(sizes[i], 100, random_base());
        repeat (4)
            send_file($urandom_range(60, 140), 85, random_base());
    endtask

    task automatic test_back_to_back();
        settle();
        quiet = 1'b1;
        repeat (8)
            send_file($urandom_range(1, 30), $urandom_range(0, 50), random_base());
        settle();
        quiet = 1'b0;
    endtask

    task automatic test_random_lists();
        int since_cfg;
        since_cfg = 0;
        while (n_blocks_in < TARGET_BLOCKS)
        begin
            if (since_cfg > 250)
            begin
                random_config();
                since_cfg = 0;
            end
            case ($urandom_range(0, 9))
                0: send_file(1, 0, random_base());
                1: send_file($urandom_range(2, 12), 100, random_base());
                2: send_file($urandom_range(40, 90), $urandom_range(60, 100), random_base());
                default: send_file($urandom_range(1, 40), $urandom_range(0, 60), random_base());
            endcase
            since_cfg = n_blocks_in - (n_blocks_in / 250) * 250 == 0 ? 251 : since_cfg + 1;
        end
    endtask

    initial
    begin
        bsb_reg  = BSB_RESET;
        part_reg = '0;
        clear_run();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_block_size();
        test_extent_limit();
        test_back_to_back();
        test_random_lists();

        settle();
        repeat (16) @(posedge clk);
        $display("Checked %0d result beats from %0d block numbers in %0d lists", n_extents_out,
                 n_blocks_in, n_lists);
        $display("%0d lists ran past the extent limit; %0d register writes", n_overflow_lists,
                 n_reg_writes);
        if (n_errors == 0)
            $display("** block_extent_coalescer: PASSED **");
        else
            $display("** block_extent_coalescer: FAILED **");
        $finish;
    end

endmodule
